// ----- rtl/olirs_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// olirs_pkg: shared types and constants
// Item layouts, operation and status codes, and the cell command bundle
// of the ordered list block.
// ----------------------------------------------------------------------------
package olirs_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int VAL_W    = 32;

    localparam logic [2:0] FUNC_INSERT = 3'd0;
    localparam logic [2:0] FUNC_APPEND = 3'd1;
    localparam logic [2:0] FUNC_REMOVE = 3'd2;
    localparam logic [2:0] FUNC_SEARCH = 3'd3;
    localparam logic [2:0] FUNC_CLEAR  = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;

    typedef struct packed {
        logic [2:0]              func;
        logic signed [VAL_W-1:0] value;
    } req_item_t;

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] position;
        logic [4:0] count;
        logic       empty_res;
    } rsp_item_t;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_PUSH_FRONT,
        CMD_PUSH_BACK,
        CMD_MATCH,
        CMD_SCAN,
        CMD_PULL
    } cell_cmd_t;

    typedef struct packed {
        cell_cmd_t               cmd;
        logic signed [VAL_W-1:0] key;
        logic [IDX_W-1:0]        pos;
        logic [CNT_W-1:0]        count;
    } cell_ctrl_t;

endpackage
`default_nettype wire

// ----- rtl/olirs_cell.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// olirs_cell: one list slot
// Holds one entry and a hit flag; shifts entries and hits to and from its
// neighbors under the broadcast command.
// ----------------------------------------------------------------------------
module olirs_cell (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire olirs_pkg::cell_ctrl_t             ctrl,
    input  wire logic [olirs_pkg::IDX_W-1:0]       idx,
    input  wire logic signed [olirs_pkg::VAL_W-1:0] left_entry,
    input  wire logic signed [olirs_pkg::VAL_W-1:0] right_entry,
    input  wire logic                              right_hit,
    output logic signed [olirs_pkg::VAL_W-1:0]     entry,
    output logic                                   hit
);
    import olirs_pkg::*;

    logic signed [VAL_W-1:0] entry_reg;
    logic signed [VAL_W-1:0] entry_next;
    logic                    hit_reg;
    logic                    hit_next;
    logic                    in_use;

    assign in_use = CNT_W'(idx) < ctrl.count;

    always_comb
    begin
        entry_next = entry_reg;
        hit_next   = hit_reg;
        case (ctrl.cmd)
            CMD_PUSH_FRONT: entry_next = (idx == '0) ? ctrl.key : left_entry;
            CMD_PUSH_BACK:
            begin
                if (CNT_W'(idx) == ctrl.count)
                begin
                    entry_next = ctrl.key;
                end
            end
            CMD_MATCH:      hit_next = in_use && (entry_reg == ctrl.key);
            CMD_SCAN:       hit_next = right_hit;
            CMD_PULL:
            begin
                if (idx >= ctrl.pos)
                begin
                    entry_next = right_entry;
                end
            end
            default:        ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else
        begin
            hit_reg <= hit_next;
        end
    end

    assign entry = entry_reg;
    assign hit   = hit_reg;

endmodule
`default_nettype wire

// ----- rtl/ordered_list_insert_remove_search_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ordered_list_insert_remove_search_top: bounded ordered list
// Row of slot cells under a small sequencer; insert, append, remove,
// search and clear on a list of signed 32-bit values.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid/req_ready/req) carries one item: func, value.
//   rsp channel (rsp_valid/rsp_ready/rsp) returns one item per request:
//   status, position, count, empty_res.
//   One request is in work at a time; req_ready is high only while the
//   sequencer is idle.
//   Steps from accept to rsp_valid: insert/append pass the push state
//     (none when full), clear and unused codes go straight to done,
//     search passes the match state and then scans, and remove then
//     also passes the pull state after a hit; a miss goes to done.
//   During the scan the hit flags move one cell per cycle toward
//   the head of the row.
//   The response sits in an output register; a new request is taken while
//   it waits. If the receiver stalls, the next response holds in the
//   sequencer until the register frees.
//   Reset empties the list and clears rsp_valid; entries need no clearing.
// ----------------------------------------------------------------------------
module ordered_list_insert_remove_search_top (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 req_valid,
    output logic                      req_ready,
    input  wire olirs_pkg::req_item_t req,
    output logic                      rsp_valid,
    input  wire logic                 rsp_ready,
    output olirs_pkg::rsp_item_t      rsp
);
    import olirs_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_PUSH  = 6'b000010,
        S_MATCH = 6'b000100,
        S_SCAN  = 6'b001000,
        S_PULL  = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    state_t                  state_reg, state_next;
    logic [2:0]              func_reg, func_next;
    logic signed [VAL_W-1:0] key_reg, key_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [IDX_W-1:0]        scan_reg, scan_next;
    logic [IDX_W-1:0]        pos_reg, pos_next;
    logic [1:0]              status_reg, status_next;
    logic                    rsp_valid_reg, rsp_valid_next;
    rsp_item_t               rsp_reg, rsp_next;

    cell_ctrl_t              ctrl;
    logic signed [VAL_W-1:0] cell_entry [CAPACITY];
    logic                    cell_hit   [CAPACITY];
    logic                    full;
    logic                    load_rsp;

    assign full      = count_reg == CNT_W'(CAPACITY);
    assign req_ready = state_reg == S_IDLE;
    assign load_rsp  = (state_reg == S_DONE) && (!rsp_valid_reg || rsp_ready);

    always_comb
    begin
        state_next     = state_reg;
        func_next      = func_reg;
        key_next       = key_reg;
        count_next     = count_reg;
        scan_next      = scan_reg;
        pos_next       = pos_reg;
        status_next    = status_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        ctrl.cmd       = CMD_NONE;
        ctrl.key       = key_reg;
        ctrl.pos       = pos_reg;
        ctrl.count     = count_reg;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    func_next   = req.func;
                    key_next    = req.value;
                    pos_next    = '0;
                    status_next = ST_OK;
                    case (req.func)
                        FUNC_INSERT, FUNC_APPEND:
                        begin
                            if (full)
                            begin
                                status_next = ST_FULL;
                                state_next  = S_DONE;
                            end
                            else
                            begin
                                state_next = S_PUSH;
                            end
                        end
                        FUNC_REMOVE, FUNC_SEARCH: state_next = S_MATCH;
                        FUNC_CLEAR:
                        begin
                            count_next = '0;
                            state_next = S_DONE;
                        end
                        default:                  state_next = S_DONE;
                    endcase
                end
            end
            S_PUSH:
            begin
                ctrl.cmd   = (func_reg == FUNC_INSERT) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
                count_next = count_reg + 1'b1;
                state_next = S_DONE;
            end
            S_MATCH:
            begin
                ctrl.cmd   = CMD_MATCH;
                scan_next  = '0;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (cell_hit[0])
                begin
                    pos_next   = scan_reg;
                    state_next = (func_reg == FUNC_REMOVE) ? S_PULL : S_DONE;
                end
                else if ((CNT_W'(scan_reg) + 1'b1) >= count_reg)
                begin
                    status_next = ST_NOTFOUND;
                    state_next  = S_DONE;
                end
                else
                begin
                    ctrl.cmd  = CMD_SCAN;
                    scan_next = scan_reg + 1'b1;
                end
            end
            S_PULL:
            begin
                ctrl.cmd   = CMD_PULL;
                count_next = count_reg - 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (load_rsp)
                begin
                    rsp_valid_next     = 1'b1;
                    rsp_next.status    = status_reg;
                    rsp_next.position  = 4'(pos_reg);
                    rsp_next.count     = 5'(count_reg);
                    rsp_next.empty_res = count_reg == '0;
                    state_next         = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg   <= func_next;
        key_reg    <= key_next;
        scan_reg   <= scan_next;
        pos_reg    <= pos_next;
        status_reg <= status_next;
        rsp_reg    <= rsp_next;
    end

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic signed [VAL_W-1:0] left_entry;
        logic signed [VAL_W-1:0] right_entry;
        logic                    right_hit;

        if (i == 0)
        begin : g_head
            assign left_entry = key_reg;
        end
        else
        begin : g_body
            assign left_entry = cell_entry[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            assign right_entry = cell_entry[i];
            assign right_hit   = 1'b0;
        end
        else
        begin : g_inner
            assign right_entry = cell_entry[i+1];
            assign right_hit   = cell_hit[i+1];
        end

        olirs_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .idx         (IDX_W'(i)),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .right_hit   (right_hit),
            .entry       (cell_entry[i]),
            .hit         (cell_hit[i])
        );
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
`default_nettype wire

// ----- rtl/olirs_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// olirs_checker: port-level checks
// Watches the request and response channels of the ordered list block.
// ----------------------------------------------------------------------------
module olirs_checker (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 req_valid,
    input  wire logic                 req_ready,
    input  wire logic                 rsp_valid,
    input  wire logic                 rsp_ready,
    input  wire olirs_pkg::rsp_item_t rsp
);
    import olirs_pkg::*;

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("response item changed while stalled");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while an item is in work");

    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.empty_res == (rsp.count == '0))
        else $error("empty flag disagrees with count");

    a_miss_pos: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status == ST_FULL || rsp.status == ST_NOTFOUND)
            |-> rsp.position == '0)
        else $error("position set on a refused or missed item");

endmodule

bind ordered_list_insert_remove_search_top olirs_checker u_olirs_checker (.*);
`default_nettype wire
